// ----- hdl/eatam_pkg.sv -----
// Package for the Euler-angle to affine-matrix block: widths, CORDIC constants
// and shared types. No dependencies.
package eatam_pkg;
	localparam int CORDIC_STAGES_DEF = 24;
	localparam int ATAN_ENTRIES = 30;
	localparam int AW = 34;
	localparam logic signed [31:0] ONE_Q30 = 32'sd1073741824;
	localparam logic signed [31:0] GAIN_Q30 = 32'sd652032874;
	localparam logic signed [31:0] FULL_Q16 = 32'sd23592960;
	localparam logic [1:0] ROW_LAST = 2'd2;

	function automatic logic signed [31:0] atan_turn(input int i);
		logic signed [31:0] r;
		begin
			case (i)
				0: r = 32'sd536870912; 1: r = 32'sd316933406; 2: r = 32'sd167458907;
				3: r = 32'sd85004756; 4: r = 32'sd42667331; 5: r = 32'sd21354465;
				6: r = 32'sd10679838; 7: r = 32'sd5340245; 8: r = 32'sd2670163;
				9: r = 32'sd1335087; 10: r = 32'sd667544; 11: r = 32'sd333772;
				12: r = 32'sd166886; 13: r = 32'sd83443; 14: r = 32'sd41722;
				15: r = 32'sd20861; 16: r = 32'sd10430; 17: r = 32'sd5215;
				18: r = 32'sd2608; 19: r = 32'sd1304; 20: r = 32'sd652;
				21: r = 32'sd326; 22: r = 32'sd163; 23: r = 32'sd81;
				24: r = 32'sd41; 25: r = 32'sd20; 26: r = 32'sd10;
				27: r = 32'sd5; 28: r = 32'sd3; 29: r = 32'sd1;
				default: r = 32'sd0;
			endcase
			return r;
		end
	endfunction

	// Saturate a wide value to [-1, 1] in Q1.30.
	function automatic logic signed [31:0] sat_unit(input logic signed [AW+1:0] v);
		logic signed [31:0] r;
		begin
			if (v > AW'(ONE_Q30)) r = ONE_Q30;
			else if (v < -$signed({{(AW+2-32){1'b0}}, ONE_Q30})) r = -ONE_Q30;
			else r = v[31:0];
			return r;
		end
	endfunction

	// Rounded Q1.30 product.
	function automatic logic signed [33:0] qmul(input logic signed [31:0] a,
			input logic signed [31:0] b);
		logic signed [63:0] p;
		begin
			p = a * b + 64'sd536870912;
			return p[63:30];
		end
	endfunction

	typedef struct packed {
		logic signed [31:0] px;
		logic signed [31:0] py;
		logic signed [31:0] pz;
	} pos_t;
endpackage

// ----- hdl/euler_angles_to_affine_matrix.sv -----
// Top level of the Euler-angle to affine-matrix block.
// Depends on eatam_pkg, eatam_reduce and eatam_cordic.
//
// Each input transaction carries pitch, yaw and roll in Q15.16 degrees and an
// optional position; it yields three output transactions, the rows 0, 1 and 2
// of the 3x4 matrix (yaw*pitch)*roll with the position in column 3, the third
// flagged by last_row. Because all three rows share one output channel, the
// row serializer at the end of the pipeline takes a new matrix only when it
// is free or its last row leaves, although a burst fills the pipeline back to
// back. The pipeline has four reduction stages, N CORDIC stages (N being
// CORDIC_STAGES capped at 30), the quadrant stage, two product stages and
// the serializer load. The whole pipeline advances only when it is not held,
// so a stall on the output loses nothing: the row serializer raises stall on
// the input when a finished matrix waits behind one whose last row is not
// being taken.
module euler_angles_to_affine_matrix import eatam_pkg::*; #(
	parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  logic signed [31:0] pitch_deg,
	input  logic signed [31:0] yaw_deg,
	input  logic signed [31:0] roll_deg,
	input  logic signed [31:0] pos_x,
	input  logic signed [31:0] pos_y,
	input  logic signed [31:0] pos_z,
	input  logic with_position,
	output logic out_valid,
	input  logic out_stall,
	output logic [1:0] row_index,
	output logic signed [31:0] col_first,
	output logic signed [31:0] col_second,
	output logic signed [31:0] col_third,
	output logic signed [31:0] col_translation,
	output logic last_row
);
	localparam int N = (CORDIC_STAGES < ATAN_ENTRIES) ? CORDIC_STAGES : ATAN_ENTRIES;
	// Reduction (4) + CORDIC (N) + quadrant (1) + two product stages.
	localparam int DEPTH = N + 7;

	logic adv;
	logic [DEPTH-1:0] vld_q;
	pos_t pos_pipe [0:DEPTH-1];
	logic [1:0] qp, qy, qr;
	logic signed [30:0] up, uy, ur;
	logic signed [31:0] sp, cp, sy, cy, sr, cr;
	logic signed [31:0] crcy_s1, crsy_s1, srcy_s1, srsy_s1, sp_s1, cp_s1, sr_s1, cr_s1;
	logic signed [31:0] cy_s1, sy_s1;
	logic signed [31:0] m_s2 [0:8];
	logic [1:0] row_q;
	logic busy_q;
	logic signed [31:0] m_q [0:8];
	pos_t pos_q;

	// The serializer holds one matrix; the pipeline advances when no matrix
	// is leaving it or the matrix leaving it can be taken, that is when the
	// serializer is free or its last row leaves in this cycle.
	assign adv = !vld_q[DEPTH-1] || !busy_q || (!out_stall && row_q == ROW_LAST);
	assign in_stall = !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[DEPTH-2:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pos_pipe[0] <= with_position ? pos_t'{pos_x, pos_y, pos_z} : '0;
			for (int i = 1; i < DEPTH; i++) pos_pipe[i] <= pos_pipe[i-1];
		end
	end

	eatam_reduce u_rp (.clk, .en(adv), .ang(pitch_deg), .quad(qp), .resid(up));
	eatam_reduce u_ry (.clk, .en(adv), .ang(yaw_deg), .quad(qy), .resid(uy));
	eatam_reduce u_rr (.clk, .en(adv), .ang(roll_deg), .quad(qr), .resid(ur));
	eatam_cordic #(.STAGES(CORDIC_STAGES)) u_cp (.clk, .en(adv), .quad(qp), .resid(up),
		.sin_o(sp), .cos_o(cp));
	eatam_cordic #(.STAGES(CORDIC_STAGES)) u_cy (.clk, .en(adv), .quad(qy), .resid(uy),
		.sin_o(sy), .cos_o(cy));
	eatam_cordic #(.STAGES(CORDIC_STAGES)) u_cr (.clk, .en(adv), .quad(qr), .resid(ur),
		.sin_o(sr), .cos_o(cr));

	// First product stage: the four roll-yaw cross terms.
	always_ff @(posedge clk) begin
		if (adv) begin
			crcy_s1 <= 32'(qmul(cr, cy));
			crsy_s1 <= 32'(qmul(cr, sy));
			srcy_s1 <= 32'(qmul(sr, cy));
			srsy_s1 <= 32'(qmul(sr, sy));
			sp_s1 <= sp; cp_s1 <= cp; sr_s1 <= sr; cr_s1 <= cr;
			cy_s1 <= cy; sy_s1 <= sy;
		end
	end

	// Second product stage: the nine entries, each saturated.
	always_ff @(posedge clk) begin
		if (adv) begin
			m_s2[0] <= sat_unit(36'(qmul(cp_s1, cy_s1)));
			m_s2[1] <= sat_unit(36'(qmul(sp_s1, srcy_s1)) - 36'(crsy_s1));
			m_s2[2] <= sat_unit(36'(qmul(sp_s1, crcy_s1)) + 36'(srsy_s1));
			m_s2[3] <= sat_unit(36'(qmul(cp_s1, sy_s1)));
			m_s2[4] <= sat_unit(36'(qmul(sp_s1, srsy_s1)) + 36'(crcy_s1));
			m_s2[5] <= sat_unit(36'(qmul(sp_s1, crsy_s1)) - 36'(srcy_s1));
			m_s2[6] <= sat_unit(-36'(sp_s1));
			m_s2[7] <= sat_unit(36'(qmul(sr_s1, cp_s1)));
			m_s2[8] <= sat_unit(36'(qmul(cr_s1, cp_s1)));
		end
	end

	// Row serializer. A waiting matrix is loaded in the same cycle as the
	// last row of the previous one leaves, so rows follow with no gap.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			row_q <= '0;
		end else if (vld_q[DEPTH-1] && adv) begin
			busy_q <= 1'b1;
			row_q <= '0;
		end else if (busy_q && !out_stall) begin
			if (row_q == ROW_LAST) begin
				busy_q <= 1'b0;
				row_q <= '0;
			end else begin
				row_q <= row_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (vld_q[DEPTH-1] && adv) begin
			m_q <= m_s2;
			pos_q <= pos_pipe[DEPTH-1];
		end
	end

	assign out_valid = busy_q;
	assign row_index = row_q;
	assign last_row = (row_q == ROW_LAST);
	always_comb begin
		case (row_q)
			2'd0: begin
				col_first = m_q[0]; col_second = m_q[1]; col_third = m_q[2];
				col_translation = pos_q.px;
			end
			2'd1: begin
				col_first = m_q[3]; col_second = m_q[4]; col_third = m_q[5];
				col_translation = pos_q.py;
			end
			default: begin
				col_first = m_q[6]; col_second = m_q[7]; col_third = m_q[8];
				col_translation = pos_q.pz;
			end
		endcase
	end

	a_row_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> row_q != 2'd3) else $error("row index out of range");
	a_row_hold: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && out_stall |=> busy_q && $stable(row_q)) else $error("row lost");
	a_row_step: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && !out_stall && row_q != ROW_LAST |=> row_q == $past(row_q) + 2'd1)
		else $error("row skipped");
endmodule

// ----- hdl/eatam_reduce.sv -----
// Angle reduction: Q15.16 degrees to quadrant and residual binary angle.
// Depends on eatam_pkg. Four register stages.
module eatam_reduce import eatam_pkg::*; (
	input  logic clk,
	input  logic en,
	input  logic signed [31:0] ang,
	output logic [1:0] quad,
	output logic signed [30:0] resid
);
	// Whole degrees are offset by 92 turns (33120) so they are never negative;
	// the sign bit flip adds 32768 and the constant adds the remaining 352.
	localparam logic [16:0] DEG_OFFSET = 17'd352;
	// ceil(2^24 / 360), exact for every offset degree count.
	localparam logic [15:0] INV360_Q24 = 16'd46604;
	// ceil(2^29 / 360), exact for every remainder numerator below.
	localparam logic [20:0] INV360_Q29 = 21'd1491309;
	// floor(2^32 / 360) and floor(2^16 / 360).
	localparam logic [23:0] TURN_PER_DEG = 24'd11930464;
	localparam logic [7:0] TURN_PER_FRAC = 8'd182;

	logic [16:0] deg_off;
	logic [31:0] quo_prod;
	logic [16:0] deg_s1;
	logic [7:0] turns_s1;
	logic [15:0] frac_s1;
	logic [8:0] deg_s2;
	logic [15:0] frac_s2;
	logic [20:0] rem_num;
	logic [40:0] rem_prod;
	logic [31:0] t_s3;

	// Whole turns in the offset degree count, by reciprocal multiplication.
	always_comb begin
		deg_off = {1'b0, ~ang[31], ang[30:16]} + DEG_OFFSET;
		quo_prod = 32'(deg_off) * 32'(INV360_Q24);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			deg_s1 <= deg_off;
			turns_s1 <= quo_prod[31:24];
			frac_s1 <= ang[15:0];
		end
	end

	// Whole degrees modulo 360, in [0, 359].
	always_ff @(posedge clk) begin
		if (en) begin
			deg_s2 <= 9'(deg_s1 - 17'(turns_s1) * 17'd360);
			frac_s2 <= frac_s1;
		end
	end

	// t = (a*65536 + 180) / 360 with a = deg*65536 + frac, split into the
	// exact multiples of 360 and a small remainder divided by reciprocal.
	always_comb begin
		rem_num = 21'({deg_s2, 8'd0}) + 21'({frac_s2, 4'd0}) + 21'd180;
		rem_prod = 41'(rem_num) * 41'(INV360_Q29);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			t_s3 <= 32'(deg_s2) * 32'(TURN_PER_DEG) + 32'(frac_s2) * 32'(TURN_PER_FRAC)
				+ 32'(rem_prod[40:29]);
		end
	end

	// A residual of 45 degrees or more moves to the next quadrant, which is
	// the same as reading the low 30 bits as a signed number.
	always_ff @(posedge clk) begin
		if (en) begin
			resid <= $signed({t_s3[29], t_s3[29:0]});
			quad <= t_s3[31:30] + {1'b0, t_s3[29]};
		end
	end
endmodule

// ----- hdl/eatam_cordic.sv -----
// Pipelined rotation-mode CORDIC, one register stage per iteration,
// followed by saturation and quadrant rotation. Depends on eatam_pkg.
module eatam_cordic import eatam_pkg::*; #(
	parameter int STAGES = CORDIC_STAGES_DEF
) (
	input  logic clk,
	input  logic en,
	input  logic [1:0] quad,
	input  logic signed [30:0] resid,
	output logic signed [31:0] sin_o,
	output logic signed [31:0] cos_o
);
	localparam int N = (STAGES < ATAN_ENTRIES) ? STAGES : ATAN_ENTRIES;
	logic signed [AW-1:0] x_s [0:N];
	logic signed [AW-1:0] y_s [0:N];
	logic signed [31:0] z_s [0:N];
	logic [1:0] q_s [0:N];
	logic signed [31:0] s_sat, c_sat;

	always_comb begin
		x_s[0] = AW'(GAIN_Q30);
		y_s[0] = '0;
		z_s[0] = 32'(resid);
		q_s[0] = quad;
	end

	for (genvar i = 0; i < N; i++) begin : g_it
		always_ff @(posedge clk) begin
			if (en) begin
				q_s[i+1] <= q_s[i];
				if (z_s[i] >= 0) begin
					x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] - atan_turn(i);
				end else begin
					x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] + atan_turn(i);
				end
			end
		end
	end

	always_comb begin
		c_sat = sat_unit((AW+2)'(x_s[N]));
		s_sat = sat_unit((AW+2)'(y_s[N]));
	end

	always_ff @(posedge clk) begin
		if (en) begin
			case (q_s[N])
				2'd0: begin sin_o <= s_sat; cos_o <= c_sat; end
				2'd1: begin sin_o <= c_sat; cos_o <= -s_sat; end
				2'd2: begin sin_o <= -s_sat; cos_o <= -c_sat; end
				default: begin sin_o <= -c_sat; cos_o <= s_sat; end
			endcase
		end
	end
endmodule

// ----- test/eatam_matrix_checker.sv -----
// Checker for the Euler-angle to affine-matrix block: predicts the three matrix rows
// of every accepted input transaction and compares them with the output transactions.
// Depends on eatam_pkg for the CORDIC constants.
`timescale 1ns / 1ps
module eatam_matrix_checker import eatam_pkg::*; #(
	parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic in_stall,
	input  logic signed [31:0] pitch_deg,
	input  logic signed [31:0] yaw_deg,
	input  logic signed [31:0] roll_deg,
	input  logic signed [31:0] pos_x,
	input  logic signed [31:0] pos_y,
	input  logic signed [31:0] pos_z,
	input  logic with_position,
	input  logic out_valid,
	input  logic out_stall,
	input  logic [1:0] row_index,
	input  logic signed [31:0] col_first,
	input  logic signed [31:0] col_second,
	input  logic signed [31:0] col_third,
	input  logic signed [31:0] col_translation,
	input  logic last_row,
	output int errors,
	output int pending_rows,
	output int rows_seen
);
	typedef struct packed {
		logic [1:0] idx;
		logic signed [31:0] c0;
		logic signed [31:0] c1;
		logic signed [31:0] c2;
		logic signed [31:0] tr;
		logic lst;
	} matrix_row_t;

	localparam longint UNIT = 64'sd1073741824;

	matrix_row_t expected_rows[$];
	longint arctan_tbl[30] = '{536870912, 316933406, 167458907, 85004756, 42667331,
		21354465, 10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
		41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20, 10, 5, 3, 1};

	function automatic longint clamp_unit(longint v);
		if (v > UNIT) return UNIT;
		if (v < -UNIT) return -UNIT;
		return v;
	endfunction

	function automatic longint fx_mul(longint a, longint b);
		return (a * b + (64'sd1 << 29)) >>> 30;
	endfunction

	task automatic angle_sincos(input logic signed [31:0] ang, output longint sn,
			output longint cs);
		longint a, t, u, x, y, z, nx, s, c;
		int q;
		a = longint'(ang) % 64'sd23592960;
		if (a < 0) a += 64'sd23592960;
		t = (a * 65536 + 180) / 360;
		q = int'((t >> 30) & 3);
		u = t & 64'h3FFFFFFF;
		if (u >= (64'sd1 << 29)) begin
			u -= (64'sd1 << 30);
			q = (q + 1) & 3;
		end
		x = 652032874;
		y = 0;
		z = u;
		for (int i = 0; i < CORDIC_STAGES && i < 30; i++) begin
			if (z >= 0) begin
				nx = x - (y >>> i);
				y = y + (x >>> i);
				z -= arctan_tbl[i];
			end else begin
				nx = x + (y >>> i);
				y = y - (x >>> i);
				z += arctan_tbl[i];
			end
			x = nx;
		end
		c = clamp_unit(x);
		s = clamp_unit(y);
		case (q)
			0: begin sn = s; cs = c; end
			1: begin sn = c; cs = -s; end
			2: begin sn = -s; cs = -c; end
			default: begin sn = -c; cs = s; end
		endcase
	endtask

	task automatic predict_matrix();
		longint sp, cp, sy, cy, sr, cr, crcy, crsy, srcy, srsy;
		longint m[3][3];
		logic signed [31:0] pos[3];
		matrix_row_t row;
		angle_sincos(pitch_deg, sp, cp);
		angle_sincos(yaw_deg, sy, cy);
		angle_sincos(roll_deg, sr, cr);
		crcy = fx_mul(cr, cy);
		crsy = fx_mul(cr, sy);
		srcy = fx_mul(sr, cy);
		srsy = fx_mul(sr, sy);
		m[0][0] = fx_mul(cp, cy);
		m[0][1] = fx_mul(sp, srcy) - crsy;
		m[0][2] = fx_mul(sp, crcy) + srsy;
		m[1][0] = fx_mul(cp, sy);
		m[1][1] = fx_mul(sp, srsy) + crcy;
		m[1][2] = fx_mul(sp, crsy) - srcy;
		m[2][0] = -sp;
		m[2][1] = fx_mul(sr, cp);
		m[2][2] = fx_mul(cr, cp);
		pos = '{pos_x, pos_y, pos_z};
		for (int r = 0; r < 3; r++) begin
			row.idx = 2'(r);
			row.c0 = 32'(clamp_unit(m[r][0]));
			row.c1 = 32'(clamp_unit(m[r][1]));
			row.c2 = 32'(clamp_unit(m[r][2]));
			row.tr = with_position ? pos[r] : 32'sd0;
			row.lst = (2'(r) == ROW_LAST);
			expected_rows.push_back(row);
		end
	endtask

	task automatic compare_row();
		matrix_row_t e;
		if (expected_rows.size() == 0) begin
			$error("unexpected row transaction, row_index %0d", row_index);
			errors++;
			return;
		end
		e = expected_rows.pop_front();
		if (row_index !== e.idx) begin
			$error("row_index expected %0d actual %0d", e.idx, row_index); errors++;
		end
		if (col_first !== e.c0) begin
			$error("col_first expected %0d actual %0d", e.c0, col_first); errors++;
		end
		if (col_second !== e.c1) begin
			$error("col_second expected %0d actual %0d", e.c1, col_second); errors++;
		end
		if (col_third !== e.c2) begin
			$error("col_third expected %0d actual %0d", e.c2, col_third); errors++;
		end
		if (col_translation !== e.tr) begin
			$error("col_translation expected %0d actual %0d", e.tr, col_translation);
			errors++;
		end
		if (last_row !== e.lst) begin
			$error("last_row expected %0d actual %0d", e.lst, last_row); errors++;
		end
	endtask

	initial begin
		errors = 0;
		rows_seen = 0;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) predict_matrix();
			if (out_valid && !out_stall) begin
				compare_row();
				rows_seen++;
			end
		end
	end

	assign pending_rows = expected_rows.size();
endmodule

// ----- test/tb_euler_angles_to_affine_matrix.sv -----
// Testbench top for the Euler-angle to affine-matrix block: drives angle
// transactions with random gaps and output stalls. Depends on eatam_pkg,
// the block and eatam_matrix_checker.
`timescale 1ns / 1ps
module tb_euler_angles_to_affine_matrix;
	import eatam_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [31:0] pitch_deg = '0;
	logic signed [31:0] yaw_deg = '0;
	logic signed [31:0] roll_deg = '0;
	logic signed [31:0] pos_x = '0;
	logic signed [31:0] pos_y = '0;
	logic signed [31:0] pos_z = '0;
	logic with_position = 1'b0;
	logic out_valid;
	logic out_stall = 1'b1;
	logic [1:0] row_index;
	logic signed [31:0] col_first, col_second, col_third, col_translation;
	logic last_row;
	int errors, pending_rows, rows_seen;
	int sent = 0;

	// Receiver behavior: 0 random stalls, 1 never stalls, 2 long hold-off.
	int sink_mode = 0;
	// Sender behavior: when set, the source never idles between transactions.
	bit source_eager = 1'b0;

	localparam int RANDOM_ITEMS = 330;
	// More transactions than the pipeline holds, so the input gets stalled.
	localparam int HOLD_ITEMS = 60;
	localparam int HOLD_CYCLES = 150;

	always #5 clk = ~clk;

	euler_angles_to_affine_matrix dut (.*);

	eatam_matrix_checker checker_i (.*);

	// Output side. In random mode the stall is redrawn every cycle; during
	// the hold-off the stall stays high so the pipeline fills and the block
	// pushes back on the input channel.
	always @(posedge clk) begin
		if (!arst_n) out_stall <= 1'b1;
		else if (sink_mode == 1) out_stall <= 1'b0;
		else if (sink_mode == 2) out_stall <= 1'b1;
		else out_stall <= ($urandom_range(99) < 25);
	end

	// Offers one transaction and holds it until the block takes it. The
	// idle gap comes first so that valid is never dropped and raised in
	// the same step.
	task automatic send_angles(input logic signed [31:0] p, y, r, px, py, pz,
			input logic wp);
		while (!source_eager && $urandom_range(99) < 25) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		pitch_deg <= p;
		yaw_deg <= y;
		roll_deg <= r;
		pos_x <= px;
		pos_y <= py;
		pos_z <= pz;
		with_position <= wp;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sent++;
	endtask

	function automatic logic signed [31:0] random_angle();
		case ($urandom_range(3))
			0: return $urandom;
			// Exact multiples of 45 degrees hit the quadrant boundaries.
			1: return 32'(($urandom_range(32) - 16) * 45) <<< 16;
			2: return 32'($urandom_range(720)) - 32'sd360 <<< 16;
			default: return 32'($urandom_range(2 * 23592960)) - 32'sd23592960;
		endcase
	endfunction

	task automatic send_random();
		send_angles(random_angle(), random_angle(), random_angle(), $urandom, $urandom,
			$urandom, 1'($urandom_range(1)));
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: zero angles, field extremes, quarter turns, the
		// half-up rounding point and the case with no position.
		send_angles(0, 0, 0, 0, 0, 0, 1'b0);
		send_angles(32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF, 32'sh7FFFFFFF,
			32'sh80000000, 32'shFFFFFFFF, 1'b1);
		send_angles(32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000, 32'sh80000000,
			32'sh7FFFFFFF, 0, 1'b0);
		send_angles(90 <<< 16, 180 <<< 16, 270 <<< 16, 32'h55555555, 32'hAAAAAAAA,
			1, 1'b1);
		send_angles(-90 <<< 16, 360 <<< 16, -180 <<< 16, 32'hAAAAAAAA, 32'h55555555,
			-1, 1'b1);
		send_angles(45 <<< 16, -45 <<< 16, 135 <<< 16, 5, 6, 7, 1'b0);
		send_angles(32'sd23592960, -32'sd23592960, 32'sd23592959, 1, 2, 3, 1'b1);
		send_angles(1, -1, 32'sd11796480, 32'h00010000, 0, 0, 1'b1);
		send_angles(30 <<< 16, 60 <<< 16, -120 <<< 16, 0, 32'h7FFF0000, 0, 1'b1);

		// Hold-off: the receiver stalls for a long stretch while the sender
		// keeps offering, counted by the receiver's own process.
		fork
			begin
				sink_mode = 2;
				repeat (HOLD_CYCLES) @(posedge clk);
				sink_mode = 0;
			end
			repeat (HOLD_ITEMS) send_random();
		join

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			// A stretch with no idling on either side.
			if (n == 150) begin
				sink_mode = 1;
				source_eager = 1'b1;
			end
			if (n == 230) begin
				sink_mode = 0;
				source_eager = 1'b0;
			end
			send_random();
		end
		in_valid <= 1'b0;

		while (pending_rows != 0) @(posedge clk);
		repeat (CORDIC_STAGES_DEF + 20) @(posedge clk);

		$display("Covered %0d input transactions with %0d matrix rows checked,",
			sent, rows_seen);
		$display("including extreme angles, quarter turns and a long output hold-off.");
		if (errors == 0 && pending_rows == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

	// Watchdog, far beyond the slowest correct run.
	initial begin
		#2000000;
		$display("FAILED: results differ");
		$finish;
	end
endmodule
